FILE: hdl/mclk_pkg.sv
// ----------------------------------------------------------------------------
// Mains clock package
// Shared types, register indexes, mode codes and field-step helpers for the
// mains-synchronized clock with two-button setting.
// ----------------------------------------------------------------------------
package mclk_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_CYCLES_PER_SEC = 3'd0;
    localparam logic [2:0] CFG_COLON_BELOW    = 3'd1;
    localparam logic [2:0] CFG_DEBOUNCE       = 3'd2;
    localparam logic [2:0] CFG_REPEAT_DELAY   = 3'd3;
    localparam logic [2:0] CFG_REPEAT_PERIOD  = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT        = 3'd5;

    // Configuration reset values
    localparam logic [5:0]  RST_CYCLES_PER_SEC = 6'd50;
    localparam logic [5:0]  RST_COLON_BELOW    = 6'd25;
    localparam logic [7:0]  RST_DEBOUNCE       = 8'd50;
    localparam logic [7:0]  RST_REPEAT_DELAY   = 8'd200;
    localparam logic [7:0]  RST_REPEAT_PERIOD  = 8'd125;
    localparam logic [15:0] RST_TIMEOUT        = 16'd32000;

    // Time reset values
    localparam logic [4:0] RST_HOURS   = 5'd12;
    localparam logic [5:0] RST_MINUTES = 6'd34;
    localparam logic [5:0] RST_SECONDS = 6'd56;

    // Setting modes
    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_HOURS      = 3'd1;
    localparam logic [2:0] MODE_MINUTES    = 3'd2;
    localparam logic [2:0] MODE_ALARM_ON   = 3'd3;
    localparam logic [2:0] MODE_ALARM_HRS  = 3'd4;
    localparam logic [2:0] MODE_ALARM_MINS = 3'd5;
    localparam logic [2:0] MODE_SLEEP      = 3'd6;
    localparam logic [2:0] MODE_UNUSED     = 3'd7;

    // Button codes
    localparam logic [1:0] BTN_NONE = 2'd0;
    localparam logic [1:0] BTN_MODE = 2'd1;
    localparam logic [1:0] BTN_SET  = 2'd2;
    localparam logic [1:0] BTN_BOTH = 2'd3;

    // Debouncer phases
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_DELAY    = 2'd2,
        PH_REPEAT   = 2'd3
    } debounce_phase_t;

    // Clock state carried on the result beat, plus the idle countdown and the two pulses
    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [2:0]  mode;
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minutes;
        logic        alarm_on;
        logic [15:0] idle;
        logic        check;
        logic        refresh;
    } clk_state_t;

    // Step an hour field, wrapping at 24
    function automatic logic [4:0] inc_mod24(input logic [4:0] v);
        logic [5:0] sum;
        sum = {1'b0, v} + 6'd1;
        return (sum >= 6'd24) ? 5'd0 : sum[4:0];
    endfunction

    // Step a minute or second field, wrapping at 60
    function automatic logic [5:0] inc_mod60(input logic [5:0] v);
        logic [6:0] sum;
        sum = {1'b0, v} + 7'd1;
        return (sum >= 7'd60) ? 6'd0 : sum[5:0];
    endfunction

    // Apply one debounced button action
    function automatic clk_state_t press_action(input clk_state_t s,
                                                input logic [1:0] b,
                                                input logic [15:0] timeout);
        clk_state_t r;
        logic [2:0] m_inc;
        r = s;
        m_inc = s.mode + 3'd1;
        if (b == BTN_MODE)
        begin
            r.mode = (m_inc == MODE_UNUSED) ? MODE_NORMAL : m_inc;
        end
        if (b == BTN_SET)
        begin
            if (s.mode == MODE_NORMAL)
            begin
                return r;
            end
            case (s.mode)
                MODE_HOURS:      r.hours = inc_mod24(s.hours);
                MODE_MINUTES:
                begin
                    r.seconds = 6'd0;
                    r.minutes = inc_mod60(s.minutes);
                end
                MODE_ALARM_ON:   r.alarm_on = ~s.alarm_on;
                MODE_ALARM_HRS:  r.alarm_hour = inc_mod24(s.alarm_hour);
                MODE_ALARM_MINS: r.alarm_minutes = inc_mod60(s.alarm_minutes);
                default:         r.alarm_on = s.alarm_on;
            endcase
            r.refresh = 1'b1;
            r.check   = 1'b1;
        end
        r.idle = (r.mode == MODE_NORMAL) ? 16'd0 : timeout;
        return r;
    endfunction

endpackage

FILE: hdl/mains_clock_with_button_setting_top.sv
// ----------------------------------------------------------------------------
// Mains clock with button setting
// Mains-synchronized time of day, colon blink, debounced two-button setting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat per 2 ms tick carrying the
//   sampled mains level and the two button bits. Output channel (out_valid /
//   out_stall): one result beat per input beat with the time, alarm fields,
//   setting mode, colon state and the check_alarm / display_refresh pulses.
//   Configuration: cfg_write_en with cfg_index and cfg_data writes one
//   register per clock; write only while no beat is in flight.
//   Path: an accepted beat is held in the input register, then processed
//   into the state/result register, which drives out_valid.
//   Throughput: one beat per clock while the result is not stalled. The input
//   register feeds one pass of update logic into the state/result register.
//   Stall: while the result is stalled the input register holds one more
//   beat; in_stall rises only when both the input and result registers are
//   full and out_stall is high.
//   Reset: time 12:34:56, normal mode, alarm 00:00 off, debouncer idle and
//   all configuration registers at their defaults.
// ----------------------------------------------------------------------------
module mains_clock_with_button_setting_top
    import mclk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mains_level,
    input  logic [1:0]  buttons,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  hours,
    output logic [5:0]  minutes,
    output logic [5:0]  seconds,
    output logic        colon_lit,
    output logic [2:0]  setting_mode,
    output logic [4:0]  alarm_hour,
    output logic [5:0]  alarm_minutes,
    output logic        alarm_enabled,
    output logic        check_alarm,
    output logic        display_refresh
);

    // Configuration registers
    logic [5:0]  cycles_per_sec_reg;
    logic [5:0]  colon_below_reg;
    logic [7:0]  debounce_ticks_reg;
    logic [7:0]  repeat_delay_reg;
    logic [7:0]  repeat_period_reg;
    logic [15:0] timeout_reg;

    // Input register
    logic        in_valid_reg;
    logic        level_reg;
    logic [1:0]  buttons_reg;

    // State and result registers
    clk_state_t      state_reg, state_next;
    logic [5:0]      cycles_left_reg, cycles_left_next;
    logic            colon_reg, colon_next;
    logic            high_seen_reg;
    debounce_phase_t phase_reg, phase_next;
    logic [1:0]      tent_reg, tent_next;
    logic [7:0]      dcount_reg, dcount_next;
    logic [7:0]      rcount_reg, rcount_next;
    logic            out_valid_reg;

    logic            process;
    logic            in_accept;

    // Handshake: process the held beat when the result slot frees
    assign process   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_per_sec_reg <= RST_CYCLES_PER_SEC;
            colon_below_reg    <= RST_COLON_BELOW;
            debounce_ticks_reg <= RST_DEBOUNCE;
            repeat_delay_reg   <= RST_REPEAT_DELAY;
            repeat_period_reg  <= RST_REPEAT_PERIOD;
            timeout_reg        <= RST_TIMEOUT;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_CYCLES_PER_SEC: cycles_per_sec_reg <= cfg_data[5:0];
                CFG_COLON_BELOW:    colon_below_reg    <= cfg_data[5:0];
                CFG_DEBOUNCE:       debounce_ticks_reg <= cfg_data[7:0];
                CFG_REPEAT_DELAY:   repeat_delay_reg   <= cfg_data[7:0];
                CFG_REPEAT_PERIOD:  repeat_period_reg  <= cfg_data[7:0];
                CFG_TIMEOUT:        timeout_reg        <= cfg_data;
                default:            timeout_reg        <= timeout_reg;
            endcase
        end
    end

    // Capture the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            level_reg   <= mains_level;
            buttons_reg <= buttons;
        end
    end

    // Compute one tick: mains edge, colon, idle timeout, debouncer
    always_comb
    begin
        logic       edge_seen;
        logic [6:0] sec_inc;
        logic       done;

        state_next       = state_reg;
        state_next.check = 1'b0;
        state_next.refresh = 1'b0;
        cycles_left_next = cycles_left_reg;
        colon_next       = colon_reg;
        phase_next       = phase_reg;
        tent_next        = tent_reg;
        dcount_next      = dcount_reg;
        rcount_next      = rcount_reg;
        done             = 1'b0;
        sec_inc          = {1'b0, state_reg.seconds} + 7'd1;
        edge_seen        = !high_seen_reg && level_reg;

        // Count down the mains divider and advance the time
        if (edge_seen)
        begin
            state_next.refresh = 1'b1;
            cycles_left_next   = cycles_left_reg - 6'd1;
            if (cycles_left_next == 6'd0)
            begin
                cycles_left_next = cycles_per_sec_reg;
                colon_next       = 1'b0;
                if (sec_inc >= 7'd60)
                begin
                    state_next.seconds = 6'd0;
                    state_next.minutes = inc_mod60(state_reg.minutes);
                    if (state_reg.minutes >= 6'd59)
                    begin
                        state_next.hours = inc_mod24(state_reg.hours);
                    end
                    state_next.check = 1'b1;
                end
                else
                begin
                    state_next.seconds = sec_inc[5:0];
                end
            end
        end

        // Light the colon in the second half of the second
        if (!colon_next && (cycles_left_next < colon_below_reg))
        begin
            colon_next         = 1'b1;
            state_next.refresh = 1'b1;
        end

        // Drop back to normal mode on idle timeout
        if (state_reg.idle == 16'd0)
        begin
            state_next.mode = MODE_NORMAL;
        end
        else
        begin
            state_next.idle = state_reg.idle - 16'd1;
        end

        // Debouncer: idle latches a new press and falls through
        if (phase_next == PH_IDLE)
        begin
            if (buttons_reg == tent_next)
            begin
                done = 1'b1;
            end
            else
            begin
                tent_next  = buttons_reg;
                phase_next = PH_DEBOUNCE;
            end
        end

        // Debounce countdown, first action
        if (!done && phase_next == PH_DEBOUNCE)
        begin
            dcount_next = dcount_next - 8'd1;
            if (buttons_reg != tent_next)
            begin
                phase_next  = PH_IDLE;
                tent_next   = BTN_NONE;
                dcount_next = debounce_ticks_reg;
                rcount_next = repeat_delay_reg;
                done        = 1'b1;
            end
            else if (dcount_next != 8'd0)
            begin
                done = 1'b1;
            end
            else
            begin
                state_next = press_action(state_next, buttons_reg, timeout_reg);
                phase_next = PH_DELAY;
            end
        end

        // Repeat delay countdown, first repeat
        if (!done && phase_next == PH_DELAY)
        begin
            rcount_next = rcount_next - 8'd1;
            done        = 1'b1;
            if (buttons_reg != tent_next)
            begin
                phase_next  = PH_IDLE;
                tent_next   = BTN_NONE;
                dcount_next = debounce_ticks_reg;
                rcount_next = repeat_delay_reg;
            end
            else if (rcount_next == 8'd0)
            begin
                state_next  = press_action(state_next, buttons_reg, timeout_reg);
                phase_next  = PH_REPEAT;
                rcount_next = repeat_period_reg - 8'd1;
            end
        end

        // Auto-repeat until release
        if (!done && phase_next == PH_REPEAT)
        begin
            if (buttons_reg == BTN_NONE)
            begin
                phase_next  = PH_IDLE;
                tent_next   = BTN_NONE;
                dcount_next = debounce_ticks_reg;
                rcount_next = repeat_delay_reg;
            end
            else if (rcount_next <= 8'd1)
            begin
                state_next  = press_action(state_next, buttons_reg, timeout_reg);
                rcount_next = repeat_period_reg - 8'd1;
            end
            else
            begin
                rcount_next = rcount_next - 8'd1;
            end
        end
    end

    // Advance state on each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.hours         <= RST_HOURS;
            state_reg.minutes       <= RST_MINUTES;
            state_reg.seconds       <= RST_SECONDS;
            state_reg.mode          <= MODE_NORMAL;
            state_reg.alarm_hour    <= 5'd0;
            state_reg.alarm_minutes <= 6'd0;
            state_reg.alarm_on      <= 1'b0;
            state_reg.idle          <= 16'd0;
            state_reg.check         <= 1'b0;
            state_reg.refresh       <= 1'b0;
            cycles_left_reg         <= RST_CYCLES_PER_SEC;
            colon_reg               <= 1'b0;
            high_seen_reg           <= 1'b0;
            phase_reg               <= PH_IDLE;
            tent_reg                <= BTN_NONE;
            dcount_reg              <= RST_DEBOUNCE;
            rcount_reg              <= RST_REPEAT_DELAY;
        end
        else if (process)
        begin
            state_reg       <= state_next;
            cycles_left_reg <= cycles_left_next;
            colon_reg       <= colon_next;
            high_seen_reg   <= level_reg;
            phase_reg       <= phase_next;
            tent_reg        <= tent_next;
            dcount_reg      <= dcount_next;
            rcount_reg      <= rcount_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Drive the result ports
    assign out_valid       = out_valid_reg;
    assign hours           = state_reg.hours;
    assign minutes         = state_reg.minutes;
    assign seconds         = state_reg.seconds;
    assign colon_lit       = colon_reg;
    assign setting_mode    = state_reg.mode;
    assign alarm_hour      = state_reg.alarm_hour;
    assign alarm_minutes   = state_reg.alarm_minutes;
    assign alarm_enabled   = state_reg.alarm_on;
    assign check_alarm     = state_reg.check;
    assign display_refresh = state_reg.refresh;

endmodule

FILE: hdl/mclk_checker.sv
// ----------------------------------------------------------------------------
// Mains clock port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module mclk_checker
    import mclk_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write_en,
    input logic [2:0]  cfg_index,
    input logic [15:0] cfg_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic        mains_level,
    input logic [1:0]  buttons,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  hours,
    input logic [5:0]  minutes,
    input logic [5:0]  seconds,
    input logic        colon_lit,
    input logic [2:0]  setting_mode,
    input logic [4:0]  alarm_hour,
    input logic [5:0]  alarm_minutes,
    input logic        alarm_enabled,
    input logic        check_alarm,
    input logic        display_refresh
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hours) && $stable(minutes)
            && $stable(seconds) && $stable(setting_mode) && $stable(colon_lit))
        else $error("stalled result beat changed");

    // Stall the input only behind a full, stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while result side free");

    // A fresh result beat traces back to an accepted input beat
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result beat without input beat");

    // A minute rollover or a set-button action raises check_alarm together with a refresh
    a_check_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && check_alarm |-> display_refresh)
        else $error("check_alarm without display_refresh");

    // Setting mode stays within its defined codes
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && setting_mode == MODE_UNUSED |-> $past(setting_mode) == MODE_UNUSED)
        else $error("setting mode entered unused code");

endmodule

bind mains_clock_with_button_setting_top mclk_checker u_mclk_checker (.*);

FILE: test/mclk_face_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mains clock result checker
// Tracks configuration writes and accepted tick beats, predicts the clock
// face that each tick produces, and compares every accepted result beat
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mclk_face_checker
    import mclk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mains_level,
    input  logic [1:0]  buttons,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [4:0]  hours,
    input  logic [5:0]  minutes,
    input  logic [5:0]  seconds,
    input  logic        colon_lit,
    input  logic [2:0]  setting_mode,
    input  logic [4:0]  alarm_hour,
    input  logic [5:0]  alarm_minutes,
    input  logic        alarm_enabled,
    input  logic        check_alarm,
    input  logic        display_refresh,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       colon;
        logic [2:0] mode;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minutes;
        logic       alarm_on;
        logic       check;
        logic       refresh;
    } clock_face_t;

    // Local copy of the configuration registers
    logic [5:0]  cps_cfg;
    logic [5:0]  colon_cfg;
    logic [7:0]  debounce_cfg;
    logic [7:0]  delay_cfg;
    logic [7:0]  period_cfg;
    logic [15:0] timeout_cfg;

    // Predicted clock state
    logic [4:0]  hours_now;
    logic [5:0]  minutes_now;
    logic [5:0]  seconds_now;
    logic [5:0]  cycles_left;
    logic        colon_now;
    logic        mains_high;
    logic [2:0]  mode_now;
    logic [4:0]  alarm_hour_now;
    logic [5:0]  alarm_minutes_now;
    logic        alarm_on_now;
    logic [15:0] idle_left;
    debounce_phase_t btn_phase;
    logic [1:0]  btn_tentative;
    logic [7:0]  debounce_left;
    logic [7:0]  repeat_left;
    logic        pulse_check;
    logic        pulse_refresh;

    clock_face_t expected_faces [$];
    clock_face_t want_face;
    clock_face_t seen_face;
    clock_face_t next_face;
    int errors;

    // Return the debouncer to idle with counters reloaded from the registers
    task reload_debouncer();
        btn_phase     = PH_IDLE;
        btn_tentative = BTN_NONE;
        debounce_left = debounce_cfg;
        repeat_left   = delay_cfg;
    endtask

    // Carry out one debounced button action
    task apply_button_action(input logic [1:0] b);
        if (b == BTN_MODE)
        begin
            mode_now = mode_now + 3'd1;
            if (mode_now == MODE_UNUSED)
                mode_now = MODE_NORMAL;
        end
        else if (b == BTN_SET)
        begin
            // set button in normal mode leaves even the idle countdown alone
            if (mode_now == MODE_NORMAL)
                return;
            case (mode_now)
                MODE_HOURS:
                    hours_now = (hours_now >= 5'd23) ? 5'd0 : hours_now + 5'd1;
                MODE_MINUTES:
                begin
                    seconds_now = 6'd0;
                    minutes_now = (minutes_now >= 6'd59) ? 6'd0 : minutes_now + 6'd1;
                end
                MODE_ALARM_ON:
                    alarm_on_now = ~alarm_on_now;
                MODE_ALARM_HRS:
                    alarm_hour_now = (alarm_hour_now >= 5'd23) ? 5'd0
                                                               : alarm_hour_now + 5'd1;
                MODE_ALARM_MINS:
                    alarm_minutes_now = (alarm_minutes_now >= 6'd59) ? 6'd0
                                                                     : alarm_minutes_now + 6'd1;
                default:
                    ;
            endcase
            pulse_refresh = 1'b1;
            pulse_check   = 1'b1;
        end
        idle_left = (mode_now == MODE_NORMAL) ? 16'd0 : timeout_cfg;
    endtask

    // Advance the predicted clock by one tick and build the face it shows
    task advance_clock_tick(input logic lvl, input logic [1:0] b, output clock_face_t face);
        bit done;
        pulse_check   = 1'b0;
        pulse_refresh = 1'b0;
        done          = 1'b0;

        // Count rising mains edges down to the next second
        if (!mains_high && lvl)
        begin
            mains_high  = 1'b1;
            cycles_left = cycles_left - 6'd1;
            if (cycles_left == 6'd0)
            begin
                cycles_left = cps_cfg;
                colon_now   = 1'b0;
                seconds_now = seconds_now + 6'd1;
                if (seconds_now >= 6'd60)
                begin
                    seconds_now = 6'd0;
                    minutes_now = minutes_now + 6'd1;
                    if (minutes_now >= 6'd60)
                    begin
                        minutes_now = 6'd0;
                        hours_now = (hours_now >= 5'd23) ? 5'd0 : hours_now + 5'd1;
                    end
                    pulse_check = 1'b1;
                end
            end
            pulse_refresh = 1'b1;
        end
        else if (mains_high && !lvl)
        begin
            mains_high = 1'b0;
        end

        // Light the colon in the second half of the second
        if (!colon_now && cycles_left < colon_cfg)
        begin
            colon_now     = 1'b1;
            pulse_refresh = 1'b1;
        end

        // Drop back to normal mode once the idle countdown runs out
        if (idle_left == 16'd0)
            mode_now = MODE_NORMAL;
        else
            idle_left = idle_left - 16'd1;

        // Debouncer: idle, debounce, delay before first repeat, repeating
        if (btn_phase == PH_IDLE)
        begin
            if (b == btn_tentative)
            begin
                done = 1'b1;
            end
            else
            begin
                btn_tentative = b;
                btn_phase     = PH_DEBOUNCE;
            end
        end
        if (!done && btn_phase == PH_DEBOUNCE)
        begin
            debounce_left = debounce_left - 8'd1;
            if (b != btn_tentative)
            begin
                reload_debouncer();
                done = 1'b1;
            end
            else if (debounce_left != 8'd0)
            begin
                done = 1'b1;
            end
            else
            begin
                apply_button_action(b);
                btn_phase = PH_DELAY;
            end
        end
        if (!done && btn_phase == PH_DELAY)
        begin
            repeat_left = repeat_left - 8'd1;
            if (b != btn_tentative)
            begin
                reload_debouncer();
            end
            else if (repeat_left == 8'd0)
            begin
                apply_button_action(b);
                btn_phase   = PH_REPEAT;
                repeat_left = period_cfg - 8'd1;
            end
            done = 1'b1;
        end
        if (!done)
        begin
            // repeating ends only on release
            if (b == BTN_NONE)
            begin
                reload_debouncer();
            end
            else if (repeat_left <= 8'd1)
            begin
                apply_button_action(b);
                repeat_left = period_cfg - 8'd1;
            end
            else
            begin
                repeat_left = repeat_left - 8'd1;
            end
        end

        face.hours         = hours_now;
        face.minutes       = minutes_now;
        face.seconds       = seconds_now;
        face.colon         = colon_now;
        face.mode          = mode_now;
        face.alarm_hour    = alarm_hour_now;
        face.alarm_minutes = alarm_minutes_now;
        face.alarm_on      = alarm_on_now;
        face.check         = pulse_check;
        face.refresh       = pulse_refresh;
    endtask

    // Compare one field and count a mismatch
    task check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cps_cfg           = RST_CYCLES_PER_SEC;
            colon_cfg         = RST_COLON_BELOW;
            debounce_cfg      = RST_DEBOUNCE;
            delay_cfg         = RST_REPEAT_DELAY;
            period_cfg        = RST_REPEAT_PERIOD;
            timeout_cfg       = RST_TIMEOUT;
            hours_now         = RST_HOURS;
            minutes_now       = RST_MINUTES;
            seconds_now       = RST_SECONDS;
            cycles_left       = RST_CYCLES_PER_SEC;
            colon_now         = 1'b0;
            mains_high        = 1'b0;
            mode_now          = MODE_NORMAL;
            alarm_hour_now    = 5'd0;
            alarm_minutes_now = 6'd0;
            alarm_on_now      = 1'b0;
            idle_left         = 16'd0;
            reload_debouncer();
            expected_faces.delete();
            errors = 0;
        end
        else
        begin
            // Mirror register writes
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_CYCLES_PER_SEC: cps_cfg      = cfg_data[5:0];
                    CFG_COLON_BELOW:    colon_cfg    = cfg_data[5:0];
                    CFG_DEBOUNCE:       debounce_cfg = cfg_data[7:0];
                    CFG_REPEAT_DELAY:   delay_cfg    = cfg_data[7:0];
                    CFG_REPEAT_PERIOD:  period_cfg   = cfg_data[7:0];
                    CFG_TIMEOUT:        timeout_cfg  = cfg_data;
                    default:            ;
                endcase
            end

            // Check a result beat against the oldest prediction
            if (out_valid && !out_stall)
            begin
                seen_face = '{hours, minutes, seconds, colon_lit, setting_mode, alarm_hour,
                              alarm_minutes, alarm_enabled, check_alarm, display_refresh};
                if (expected_faces.size() == 0)
                begin
                    $error("result beat arrived with no tick waiting for it");
                    errors++;
                end
                else
                begin
                    want_face = expected_faces.pop_front();
                    check_field("hours", want_face.hours, seen_face.hours);
                    check_field("minutes", want_face.minutes, seen_face.minutes);
                    check_field("seconds", want_face.seconds, seen_face.seconds);
                    check_field("colon_lit", want_face.colon, seen_face.colon);
                    check_field("setting_mode", want_face.mode, seen_face.mode);
                    check_field("alarm_hour", want_face.alarm_hour, seen_face.alarm_hour);
                    check_field("alarm_minutes", want_face.alarm_minutes,
                                seen_face.alarm_minutes);
                    check_field("alarm_enabled", want_face.alarm_on, seen_face.alarm_on);
                    check_field("check_alarm", want_face.check, seen_face.check);
                    check_field("display_refresh", want_face.refresh, seen_face.refresh);
                end
            end

            // Predict the face for an accepted tick beat
            if (in_valid && !in_stall)
            begin
                advance_clock_tick(mains_level, buttons, next_face);
                expected_faces.push_back(next_face);
            end
        end
        fail_count  <= errors;
        outstanding <= expected_faces.size();
    end

endmodule

FILE: test/mains_clock_with_button_setting_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mains clock with button setting testbench
// Drives tick beats (mains square wave plus button holds) through several
// register settings with random idling on both channels; the checker beside
// the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module mains_clock_with_button_setting_top_test;
    import mclk_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index = CFG_CYCLES_PER_SEC;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mains_level = 1'b0;
    logic [1:0]  buttons = BTN_NONE;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic        colon_lit;
    logic [2:0]  setting_mode;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minutes;
    logic        alarm_enabled;
    logic        check_alarm;
    logic        display_refresh;

    int fail_count;
    int outstanding;
    int send_idle_pct = 38;
    int recv_stall_pct = 61;

    // mains square wave generator state
    logic mains_wave = 1'b0;
    int   mains_ticks_left = 0;

    // directed ticks: {mains level, buttons}
    logic [2:0] directed_ticks [24] = '{
        3'b0_00, 3'b1_00, 3'b0_01, 3'b1_00, 3'b1_01, 3'b0_01, 3'b1_00, 3'b0_10,
        3'b1_10, 3'b0_10, 3'b1_11, 3'b0_11, 3'b1_00, 3'b0_01, 3'b1_01, 3'b0_00,
        3'b1_10, 3'b0_10, 3'b1_00, 3'b0_01, 3'b1_10, 3'b0_00, 3'b1_11, 3'b0_00
    };

    mains_clock_with_button_setting_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mains_level     (mains_level),
        .buttons         (buttons),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hours           (hours),
        .minutes         (minutes),
        .seconds         (seconds),
        .colon_lit       (colon_lit),
        .setting_mode    (setting_mode),
        .alarm_hour      (alarm_hour),
        .alarm_minutes   (alarm_minutes),
        .alarm_enabled   (alarm_enabled),
        .check_alarm     (check_alarm),
        .display_refresh (display_refresh)
    );

    mclk_face_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mains_level     (mains_level),
        .buttons         (buttons),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hours           (hours),
        .minutes         (minutes),
        .seconds         (seconds),
        .colon_lit       (colon_lit),
        .setting_mode    (setting_mode),
        .alarm_hour      (alarm_hour),
        .alarm_minutes   (alarm_minutes),
        .alarm_enabled   (alarm_enabled),
        .check_alarm     (check_alarm),
        .display_refresh (display_refresh),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Random stall on the result channel
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Send one tick beat, idling at random first, and hold it until accepted
    task send_tick(input logic lvl, input logic [1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mains_level <= lvl;
        buttons     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Next mains level: square wave of random half period, with rare glitches
    task next_mains(output logic lvl);
        if (mains_ticks_left == 0)
        begin
            mains_wave       = ~mains_wave;
            mains_ticks_left = $urandom_range(1, 3);
        end
        mains_ticks_left--;
        lvl = mains_wave;
        if ($urandom_range(15) == 0)
            lvl = ~lvl;
    endtask

    // Hold one button code for a number of ticks
    task send_run(input logic [1:0] code, input int len);
        logic lvl;
        repeat (len)
        begin
            next_mains(lvl);
            send_tick(lvl, code);
        end
    endtask

    // Stop sending and wait until every predicted result has come back
    task wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write all six registers, then drop the write enable
    task write_settings(input logic [15:0] cps, input logic [15:0] colon,
                        input logic [15:0] deb, input logic [15:0] dly,
                        input logic [15:0] per, input logic [15:0] tmo);
        logic [2:0]  reg_idx [6];
        logic [15:0] reg_val [6];
        reg_idx = '{CFG_CYCLES_PER_SEC, CFG_COLON_BELOW, CFG_DEBOUNCE,
                    CFG_REPEAT_DELAY, CFG_REPEAT_PERIOD, CFG_TIMEOUT};
        reg_val = '{cps, colon, deb, dly, per, tmo};
        cfg_write_en <= 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            cfg_index <= reg_idx[i];
            cfg_data  <= reg_val[i];
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
        // press and release once so the debouncer reloads from the new values
        send_run(BTN_MODE, 1);
        send_run(BTN_NONE, 2);
    endtask

    // Mostly well-formed press/release sequences, some noise bursts
    task run_random_ticks(input int count, input int hold_max);
        int sent;
        int pick;
        int hold;
        int gap;
        logic lvl;
        logic [1:0] code;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                hold = $urandom_range(1, 4);
                repeat (hold)
                begin
                    next_mains(lvl);
                    send_tick(lvl, 2'($urandom_range(3)));
                end
                sent += hold;
            end
            else
            begin
                code = (pick < 45) ? BTN_MODE : (pick < 88) ? BTN_SET : BTN_BOTH;
                hold = $urandom_range(1, hold_max);
                gap  = $urandom_range(1, 6);
                send_run(code, hold);
                send_run(BTN_NONE, gap);
                sent += hold + gap;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: fast debounce, period of one, longest timeout
        write_settings(16'd1, 16'd63, 16'd1, 16'd1, 16'd1, 16'd65535);
        foreach (directed_ticks[i])
            send_tick(directed_ticks[i][2], directed_ticks[i][1:0]);
        wait_for_results();

        // Sender idles less than the receiver stalls
        write_settings(16'd3, 16'd2, 16'd3, 16'd5, 16'd4, 16'd40);
        run_random_ticks(90, 20);
        wait_for_results();

        // Swap the idling rates
        send_idle_pct = 61;
        recv_stall_pct <= 38;
        write_settings(16'd63, 16'd0, 16'd2, 16'd3, 16'd1, 16'd12);
        run_random_ticks(80, 12);
        wait_for_results();

        // Full rate from here on; zero cycles per second wraps to 63
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        write_settings(16'd0, 16'd63, 16'd1, 16'd2, 16'd2, 16'd25);
        run_random_ticks(80, 10);
        wait_for_results();

        // Zero debounce count waits 256 ticks; zero timeout drops the mode at once
        write_settings(16'd1, 16'd1, 16'd0, 16'd1, 16'd255, 16'd0);
        send_run(BTN_MODE, 260);
        send_run(BTN_NONE, 2);
        wait_for_results();

        // Let the pipeline settle past its latency
        repeat (4) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[mains_clock_with_button_setting_top] OK");
        else
            $display("[mains_clock_with_button_setting_top] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200000;
        $display("[mains_clock_with_button_setting_top] ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/mclk_pkg.sv
hdl/mains_clock_with_button_setting_top.sv
hdl/mclk_checker.sv
test/mclk_face_checker.sv
test/mains_clock_with_button_setting_top_test.sv
